// ===== rtl/core/tpa_pkg.sv =====
// Package for the tanh piecewise approximation unit: formats, side-band struct,
// segment coefficients and rounded lookup tables built at elaboration.
// No dependencies.
package tpa_pkg;

    // Fixed-point formats
    localparam int IN_FRAC  = 12;
    localparam int OUT_FRAC = 16;
    localparam int X_W      = 18;
    localparam int Y_W      = 18;
    localparam int MAG_W    = OUT_FRAC + 1;

    localparam int FIT_LEN    = 10;
    localparam int COARSE_LEN = 29;
    localparam int FINE_LEN   = 171;

    // Method codes of the mode register
    typedef enum logic [1:0] {
        MODE_PLAN   = 2'd0,
        MODE_FIT    = 2'd1,
        MODE_COARSE = 2'd2,
        MODE_FINE   = 2'd3
    } t_mode;

    localparam logic [MAG_W-1:0] MAG_ONE = MAG_W'(1 << OUT_FRAC);

    // Thresholds on the input magnitude (12 fraction bits)
    localparam logic [X_W-1:0] PLAN_LIN_END  = X_W'(1 << (IN_FRAC - 1));       // 0.5
    localparam logic [X_W-1:0] PLAN_MID_END  = X_W'((19 << IN_FRAC) / 16);     // 1.1875
    localparam logic [X_W-1:0] PLAN_SAT      = X_W'((5 << IN_FRAC) / 2);       // 2.5
    localparam logic [X_W-1:0] FIT_SAT       = X_W'(5 << IN_FRAC);             // 5.0
    localparam logic [X_W-1:0] COARSE_PASS   = X_W'(1 << (IN_FRAC - 1));       // 0.5
    localparam logic [X_W-1:0] FINE_PASS     = X_W'((5 << IN_FRAC) / 16);      // 0.3125
    localparam logic [X_W-1:0] TAB_SAT       = X_W'(8 << IN_FRAC);             // 8.0

    // Fit scaling: mag = floor((c*a + b*2^IN + FIT_DIV/2) / FIT_DIV)
    localparam longint FIT_DIV   = 100000 * (1 << IN_FRAC) / (1 << OUT_FRAC);
    localparam int     RECIP_SH  = 42;
    localparam longint FIT_RECIP = (64'd1 << RECIP_SH) / FIT_DIV;

    typedef logic [MAG_W-1:0] t_coarse_tab [COARSE_LEN];
    typedef logic [MAG_W-1:0] t_fine_tab   [FINE_LEN];
    typedef logic [16:0]      t_fit_coef   [FIT_LEN];
    typedef logic [29:0]      t_fit_base   [FIT_LEN];

    // Side band that travels with each sample
    typedef struct packed {
        logic             valid;
        logic             neg;
        logic             use_fit;
        logic [MAG_W-1:0] direct;
    } t_side;

    localparam t_fit_coef FIT_COEF = '{
        17'd92426, 17'd58536, 17'd27596, 17'd11226, 17'd4292,
        17'd1602,  17'd592,   17'd218,   17'd80,    17'd30 };

    localparam logic [16:0] FIT_BASE_DEC [FIT_LEN] = '{
        17'd916,   17'd18831, 17'd49836, 17'd74267, 17'd88056,
        17'd94747, 17'd97762, 17'd99066, 17'd99616, 17'd99844 };

    // coarse values in units of 1e-6
    localparam logic [19:0] COARSE_DEC [COARSE_LEN] = '{
        20'd500000, 20'd532339, 20'd575612, 20'd615886, 20'd653180, 20'd687554,
        20'd719102, 20'd747940, 20'd774207, 20'd798054, 20'd819639, 20'd839124,
        20'd856669, 20'd872434, 20'd886572, 20'd899227, 20'd910537, 20'd920631,
        20'd929628, 20'd937639, 20'd968750, 20'd968750, 20'd968750, 20'd968750,
        20'd968750, 20'd997192, 20'd999619, 20'd999948, 20'd999995 };

    // fine values in units of 1e-12
    localparam logic [39:0] FINE_DEC [FINE_LEN] = '{
        40'd312500000000, 40'd313312229604, 40'd320340376412, 40'd327333434597,
        40'd334290819118, 40'd341211959550, 40'd348096300198, 40'd354943300194,
        40'd361752433588, 40'd368523189421, 40'd375255071794, 40'd381947599920,
        40'd388600308168, 40'd395212746092, 40'd401784478454, 40'd408315085232,
        40'd414804161622, 40'd421251318024, 40'd427656180022, 40'd434018388354,
        40'd440337598868, 40'd446613482474, 40'd452845725083, 40'd459034027536,
        40'd465178105530, 40'd471277689529, 40'd477332524668, 40'd483342370651,
        40'd489307001643, 40'd495226206145, 40'd501099786875, 40'd506927560627,
        40'd512709358142, 40'd518445023952, 40'd524134416232, 40'd529777406640,
        40'd535373880157, 40'd540923734910, 40'd546426882004, 40'd551883245340,
        40'd557292761429, 40'd562655379207, 40'd567971059841, 40'd573239776531,
        40'd578461514313, 40'd583636269854, 40'd588764051247, 40'd593844877803,
        40'd598878779836, 40'd603865798453, 40'd608805985338, 40'd613699402534,
        40'd618546122223, 40'd623346226508, 40'd628099807190, 40'd632806965546,
        40'd637467812107, 40'd642082466435, 40'd646651056899, 40'd651173720447,
        40'd655650602392, 40'd660081856180, 40'd664467643170, 40'd668808132415,
        40'd673103500437, 40'd677353931006, 40'd681559614924, 40'd685720749806,
        40'd689837539863, 40'd693910195686, 40'd697938934035, 40'd701923977626,
        40'd705865554920, 40'd709763899919, 40'd713619251957, 40'd717431855500,
        40'd721201959941, 40'd724929819405, 40'd728615692551, 40'd732259842379,
        40'd735862536040, 40'd739424044647, 40'd742944643087, 40'd746424609843,
        40'd749864226813, 40'd753263779130, 40'd756623554991, 40'd759943845487,
        40'd764842817452, 40'd771250232854, 40'd777505075554, 40'd783609785076,
        40'd789566828323, 40'd795378695007, 40'd801047893278, 40'd806576945556,
        40'd811968384563, 40'd817224749554, 40'd822348582743, 40'd827342425922,
        40'd832208817272, 40'd836950288352, 40'd841569361283, 40'd846068546092,
        40'd850450338243, 40'd854717216326, 40'd858871639908, 40'd862916047548,
        40'd866852854954, 40'd870684453288, 40'd874413207618, 40'd878041455492,
        40'd881571505649, 40'd885005636853, 40'd888346096843, 40'd891595101389,
        40'd894754833468, 40'd897827442530, 40'd900815043864, 40'd903719718056,
        40'd906543510531, 40'd909288431183, 40'd911956454067, 40'd914549517183,
        40'd917069522309, 40'd919518334910, 40'd921897784103, 40'd924209662672,
        40'd926455727144, 40'd928637697904, 40'd930757259365, 40'd932816060166,
        40'd934815713419, 40'd936757796986, 40'd938643853791, 40'd940475392157,
        40'd942253886172, 40'd943980776082, 40'd945657468701, 40'd947285337847,
        40'd948865724786, 40'd950399938700, 40'd951889257168, 40'd953334926655,
        40'd954738163012, 40'd956100151989, 40'd957422049751, 40'd958704983400,
        40'd959950051507, 40'd961158324640, 40'd962330845898, 40'd963468631449,
        40'd968098352301, 40'd975066498368, 40'd980527764768, 40'd984802089163,
        40'd988143811216, 40'd990754196757, 40'd992791947586, 40'd994381858266,
        40'd995621850551, 40'd996588632293, 40'd997342215536, 40'd997929503203,
        40'd998387123973, 40'd998743665468, 40'd999021428915, 40'd999237805099,
        40'd999619000000, 40'd999948000000, 40'd999995000000 };

    // Round-to-nearest conversions, evaluated at elaboration only
    function automatic t_fit_base make_fit_base();
        t_fit_base tab;
        for (int i = 0; i < FIT_LEN; i++) begin
            tab[i] = 30'((64'(FIT_BASE_DEC[i]) << IN_FRAC) + 64'(FIT_DIV / 2));
        end
        return tab;
    endfunction

    function automatic t_coarse_tab make_coarse();
        t_coarse_tab tab;
        for (int i = 0; i < COARSE_LEN; i++) begin
            tab[i] = MAG_W'(((64'(COARSE_DEC[i]) << OUT_FRAC) + 64'd500000) / 64'd1000000);
        end
        return tab;
    endfunction

    function automatic t_fine_tab make_fine();
        t_fine_tab tab;
        for (int i = 0; i < FINE_LEN; i++) begin
            tab[i] = MAG_W'(((64'(FINE_DEC[i]) << OUT_FRAC) + 64'd500000000000)
                            / 64'd1000000000000);
        end
        return tab;
    endfunction

    localparam t_fit_base   FIT_BASE_K = make_fit_base();
    localparam t_coarse_tab COARSE_Q   = make_coarse();
    localparam t_fine_tab   FINE_Q     = make_fine();

endpackage

// ===== rtl/core/tanh_piecewise_approximation_top.sv =====
// A request passes the magnitude, lookup, numerator, estimate, correction and
// output registers to o_valid. Throughput: one request per cycle; the whole
// pipeline advances whenever the output register is empty or being taken, so
// o_stall rises only for a valid result held by i_stall. Reset (synchronous,
// active low) clears all valid bits and sets the mode to the fine table. Top
// level of the tanh approximation unit; uses tpa_pkg, tpa_front, tpa_fit_div.
module tanh_piecewise_approximation_top (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [tpa_pkg::X_W-1:0] i_x_value,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [tpa_pkg::Y_W-1:0] o_y_value,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_data
);
    import tpa_pkg::*;

    t_mode            r_mode;
    logic             en;
    t_side            front_side, div_side;
    logic [31:0]      front_prod;
    logic [29:0]      front_base;
    logic [MAG_W-1:0] div_quot;
    logic [MAG_W-1:0] mag_sel, mag_clamp;
    logic             r_out_valid;
    logic [Y_W-1:0]   r_out_y;

    // mode register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_FINE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= t_mode'(i_cfg_data);
        end
    end

    // pipeline moves unless a result is held at the output
    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    tpa_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_valid),
        .i_x_value (i_x_value),
        .i_mode    (r_mode),
        .o_side    (front_side),
        .o_prod    (front_prod),
        .o_base    (front_base)
    );

    tpa_fit_div u_fit_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (front_side),
        .i_prod  (front_prod),
        .i_base  (front_base),
        .o_side  (div_side),
        .o_quot  (div_quot)
    );

    // stage 6: select, clamp, restore sign
    assign mag_sel   = div_side.use_fit ? div_quot : div_side.direct;
    assign mag_clamp = (mag_sel > MAG_ONE) ? MAG_ONE : mag_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_y <= div_side.neg ? (Y_W'(0) - Y_W'(mag_clamp)) : Y_W'(mag_clamp);
        end
    end

    assign o_valid   = r_out_valid;
    assign o_y_value = r_out_y;

endmodule

// ===== rtl/core/tpa_front.sv =====
// Front stages: magnitude/sign split, then segment select, table lookup and
// the fit coefficient multiply. Depends on tpa_pkg.
module tpa_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [tpa_pkg::X_W-1:0] i_x_value,
    input  tpa_pkg::t_mode          i_mode,
    output tpa_pkg::t_side          o_side,
    output logic [31:0]             o_prod,
    output logic [29:0]             o_base
);
    import tpa_pkg::*;

    logic           r_s1_valid;
    logic [X_W-1:0] r_s1_mag;
    logic           r_s1_neg;
    t_mode          r_s1_mode;
    logic [X_W-1:0] n_mag;

    t_side          r_side;
    logic [31:0]    r_prod;
    logic [29:0]    r_base;
    t_side          n_side;
    logic [3:0]     seg;
    logic [4:0]     c_idx;
    logic [7:0]     f_idx;
    logic [X_W-1:0] a;
    logic [X_W-1:0] am1;

    // stage 1: magnitude of the sample
    assign n_mag = i_x_value[X_W-1] ? (X_W'(0) - i_x_value) : i_x_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_mag  <= n_mag;
            r_s1_neg  <= i_x_value[X_W-1];
            r_s1_mode <= i_mode;
        end
    end

    // stage 2: pick segment or table entry
    assign a   = r_s1_mag;
    assign am1 = a - X_W'(1);
    assign seg = 4'(am1 >> (IN_FRAC - 1));

    always_comb begin
        // coarse table index
        if (a < X_W'(2 << IN_FRAC))       c_idx = 5'((a >> (IN_FRAC - 4)) - X_W'(8));
        else if (a < X_W'(3 << IN_FRAC))  c_idx = 5'd24;
        else if (a < X_W'(4 << IN_FRAC))  c_idx = 5'd25;
        else if (a < X_W'(5 << IN_FRAC))  c_idx = 5'd26;
        else if (a < X_W'(6 << IN_FRAC))  c_idx = 5'd27;
        else                              c_idx = 5'd28;
        // fine table index
        if (a < X_W'(1 << IN_FRAC))       f_idx = 8'((a >> (IN_FRAC - 7)) - X_W'(40));
        else if (a < X_W'(2 << IN_FRAC))  f_idx = 8'((a >> (IN_FRAC - 6)) + X_W'(24));
        else if (a < X_W'(4 << IN_FRAC))  f_idx = 8'((a >> (IN_FRAC - 3)) + X_W'(136));
        else if (a < X_W'(5 << IN_FRAC))  f_idx = 8'd168;
        else if (a < X_W'(6 << IN_FRAC))  f_idx = 8'd169;
        else                              f_idx = 8'd170;
    end

    always_comb begin
        n_side.valid   = r_s1_valid;
        n_side.neg     = r_s1_neg;
        n_side.use_fit = 1'b0;
        n_side.direct  = MAG_ONE;
        case (r_s1_mode)
            MODE_PLAN: begin
                if (a >= PLAN_SAT)
                    n_side.direct = MAG_ONE;
                else if (a < PLAN_LIN_END)
                    n_side.direct = MAG_W'({a, 4'b0});
                else if (a < PLAN_MID_END)
                    n_side.direct = MAG_W'({a, 3'b0}) + MAG_W'(1 << (OUT_FRAC - 2));
                else
                    n_side.direct = MAG_W'({a, 1'b0}) + MAG_W'((11 << OUT_FRAC) / 16);
            end
            MODE_FIT: begin
                if (a == X_W'(0))
                    n_side.direct = '0;
                else if (a > FIT_SAT)
                    n_side.direct = MAG_ONE;
                else
                    n_side.use_fit = 1'b1;
            end
            MODE_COARSE: begin
                if (a < COARSE_PASS)
                    n_side.direct = MAG_W'({a, 4'b0});
                else if (a >= TAB_SAT)
                    n_side.direct = MAG_ONE;
                else
                    n_side.direct = COARSE_Q[c_idx];
            end
            default: begin
                if (a < FINE_PASS)
                    n_side.direct = MAG_W'({a, 4'b0});
                else if (a >= TAB_SAT)
                    n_side.direct = MAG_ONE;
                else
                    n_side.direct = FINE_Q[f_idx];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_en) begin
            r_side.valid <= n_side.valid;
        end
    end

    // fit product c_j * a; a is below 2^15 whenever the fit is used
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side.neg     <= n_side.neg;
            r_side.use_fit <= n_side.use_fit;
            r_side.direct  <= n_side.direct;
            r_prod         <= 32'(FIT_COEF[seg]) * 32'(a[14:0]);
            r_base         <= FIT_BASE_K[seg];
        end
    end

    assign o_side = r_side;
    assign o_prod = r_prod;
    assign o_base = r_base;

endmodule

// ===== rtl/core/tpa_fit_div.sv =====
// Fit scaling: sum, reciprocal multiply and one-step correction that divide
// the fit value by a constant with rounding. Depends on tpa_pkg.
module tpa_fit_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  tpa_pkg::t_side            i_side,
    input  logic [31:0]               i_prod,
    input  logic [29:0]               i_base,
    output tpa_pkg::t_side            o_side,
    output logic [tpa_pkg::MAG_W-1:0] o_quot
);
    import tpa_pkg::*;

    t_side            r_s3_side, r_s4_side, r_s5_side;
    logic [31:0]      r_s3_num, r_s4_num;
    logic [MAG_W-1:0] r_s4_q0, r_s5_q;
    logic [63:0]      recip_prod;
    logic [31:0]      rem;

    assign recip_prod = 64'(r_s3_num) * 64'(FIT_RECIP);
    assign rem        = r_s4_num - 32'(r_s4_q0) * 32'(FIT_DIV);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_side.valid <= 1'b0;
            r_s4_side.valid <= 1'b0;
            r_s5_side.valid <= 1'b0;
        end else if (i_en) begin
            r_s3_side.valid <= i_side.valid;
            r_s4_side.valid <= r_s3_side.valid;
            r_s5_side.valid <= r_s4_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 3: numerator with rounding bias
            r_s3_side.neg     <= i_side.neg;
            r_s3_side.use_fit <= i_side.use_fit;
            r_s3_side.direct  <= i_side.direct;
            r_s3_num          <= i_prod + 32'(i_base);
            // stage 4: quotient estimate, low by at most one
            r_s4_side.neg     <= r_s3_side.neg;
            r_s4_side.use_fit <= r_s3_side.use_fit;
            r_s4_side.direct  <= r_s3_side.direct;
            r_s4_num          <= r_s3_num;
            r_s4_q0           <= recip_prod[RECIP_SH+MAG_W-1:RECIP_SH];
            // stage 5: fix the estimate
            r_s5_side.neg     <= r_s4_side.neg;
            r_s5_side.use_fit <= r_s4_side.use_fit;
            r_s5_side.direct  <= r_s4_side.direct;
            r_s5_q            <= r_s4_q0 + MAG_W'(rem >= 32'(FIT_DIV));
        end
    end

    assign o_side = r_s5_side;
    assign o_quot = r_s5_q;

endmodule

// ===== rtl/core/tpa_props.sv =====
// Port-level checks for the tanh approximation unit, bound to the top level.
// Depends on tanh_piecewise_approximation_top.
module tpa_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [17:0] o_y_value
);

    // held result keeps its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_y_value)))
        else $error("held result changed");

    // result stays within -1.0 .. 1.0
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_y_value) <= 18'sd65536 && $signed(o_y_value) >= -18'sd65536))
        else $error("result out of range");

    // input side only stalls behind a held result
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("stall without held result");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");

endmodule

bind tanh_piecewise_approximation_top tpa_props u_tpa_props (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_stall   (o_stall),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_y_value (o_y_value)
);

// ===== tb/tanh_check.sv =====
// Checker for the tanh approximation unit: watches request and result channels,
// predicts each result from its own model of the four methods and compares.
// Depends on tpa_pkg for widths, mode codes and the fine table values.
module tanh_check (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic                    i_stall_in,
    input  logic [tpa_pkg::X_W-1:0] i_x_value,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic [tpa_pkg::Y_W-1:0] i_y_value,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [1:0]              i_cfg_data,
    output int                      o_errors,
    output int                      o_pending,
    output int                      o_results
);
    timeunit 1ns;
    timeprecision 1ps;
    import tpa_pkg::*;

    localparam longint ONE_IN  = 64'd1 << IN_FRAC;
    localparam longint ONE_OUT = 64'd1 << OUT_FRAC;

    // Fit coefficients (units of 1e-5)
    localparam longint SLOPE [10] = '{92426, 58536, 27596, 11226, 4292,
                                      1602, 592, 218, 80, 30};
    localparam longint OFFS  [10] = '{916, 18831, 49836, 74267, 88056,
                                      94747, 97762, 99066, 99616, 99844};
    // Coarse breakpoints in 1/16 and values in 1e-6
    localparam longint CBP [29] = '{9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19, 20,
        21, 22, 23, 24, 25, 26, 27, 28, 29, 30, 31, 32, 48, 64, 80, 96, 128};
    localparam longint CVAL [29] = '{500000, 532339, 575612, 615886, 653180,
        687554, 719102, 747940, 774207, 798054, 819639, 839124, 856669, 872434,
        886572, 899227, 910537, 920631, 929628, 937639, 968750, 968750, 968750,
        968750, 968750, 997192, 999619, 999948, 999995};

    t_mode      mode;
    logic [Y_W-1:0] y_queue [$];

    function automatic longint round_out(longint num, longint den);
        return ((num << OUT_FRAC) + den / 2) / den;
    endfunction

    // Fine breakpoint j in units of 1/128
    function automatic longint fine_break(int j);
        if (j < 88) return 41 + j;
        if (j < 152) return 130 + 2 * (j - 88);
        if (j < 168) return 272 + 16 * (j - 152);
        case (j - 168)
            0: return 640;
            1: return 768;
            default: return 1024;
        endcase
    endfunction

    function automatic logic [Y_W-1:0] tanh_of(logic [X_W-1:0] x, t_mode m);
        logic   neg;
        longint a, mag;
        int     j;
        neg = x[X_W-1];
        a   = neg ? (64'd1 << X_W) - longint'(x) : longint'(x);
        mag = 0;
        case (m)
            MODE_PLAN: begin
                if (2 * a >= 5 * ONE_IN) mag = ONE_OUT;
                else if (2 * a < ONE_IN) mag = round_out(8 * a, ONE_IN << 3);
                else if (16 * a < 19 * ONE_IN)
                    mag = round_out(4 * a + 2 * ONE_IN, ONE_IN << 3);
                else mag = round_out(a + 11 * (ONE_IN >> 1), ONE_IN << 3);
            end
            MODE_FIT: begin
                if (a > 5 * ONE_IN) mag = ONE_OUT;
                else begin
                    for (j = 0; j < 10; j++)
                        if (2 * a <= (j + 1) * ONE_IN) break;
                    if (j >= 10) j = 9;
                    mag = round_out(SLOPE[j] * a + OFFS[j] * ONE_IN, 100000 * ONE_IN);
                end
                if (a == 0) mag = 0;
            end
            MODE_COARSE: begin
                if (2 * a < ONE_IN) mag = round_out(a, ONE_IN);
                else if (a >= 8 * ONE_IN) mag = ONE_OUT;
                else begin
                    for (j = 0; j < 29; j++)
                        if (16 * a < CBP[j] * ONE_IN) break;
                    if (j >= 29) j = 28;
                    mag = round_out(CVAL[j], 1000000);
                end
            end
            default: begin
                if (16 * a < 5 * ONE_IN) mag = round_out(a, ONE_IN);
                else if (a >= 8 * ONE_IN) mag = ONE_OUT;
                else begin
                    for (j = 0; j < FINE_LEN; j++)
                        if (128 * a < fine_break(j) * ONE_IN) break;
                    if (j >= FINE_LEN) j = FINE_LEN - 1;
                    // table value in 1e-12, scaled as (v * 2^16 + h) / 1e12
                    mag = (longint'(FINE_DEC[j]) * ONE_OUT + 64'd500000000000)
                          / 64'd1000000000000;
                end
            end
        endcase
        if (mag > ONE_OUT) mag = ONE_OUT;
        if (neg) mag = -mag;
        return Y_W'(mag);
    endfunction

    assign o_pending = y_queue.size();

    // Track mode, queue predictions, compare results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode      <= MODE_FINE;
            o_errors  <= 0;
            o_results <= 0;
            y_queue.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) mode <= t_mode'(i_cfg_data);
            if (i_valid && !i_stall_in) y_queue.push_back(tanh_of(i_x_value, mode));
            if (i_out_valid && !i_out_stall) begin
                o_results <= o_results + 1;
                if (y_queue.size() == 0) begin
                    $display("%0t: unexpected result y=%0d", $time,
                             $signed(i_y_value));
                    o_errors <= o_errors + 1;
                end else begin
                    if (y_queue[0] !== i_y_value) begin
                        $display("%0t: y_value mismatch expected %0d actual %0d",
                                 $time, $signed(y_queue[0]), $signed(i_y_value));
                        o_errors <= o_errors + 1;
                    end
                    void'(y_queue.pop_front());
                end
            end
        end
    end
endmodule

// ===== tb/tb.sv =====
// Testbench top for the tanh approximation unit: clock, reset, mode writes and
// sample stimulus with random gaps and stalls. Uses tanh_check and tpa_pkg.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tpa_pkg::*;

    localparam int HOLD_CYCLES = 200;

    logic           clk = 0;
    logic           rst_n = 0;
    logic           x_valid = 0;
    logic           x_stall;
    logic [X_W-1:0] x_value = '0;
    logic           y_valid;
    logic           y_stall = 0;
    logic [Y_W-1:0] y_value;
    logic           cfg_valid = 0;
    logic           cfg_ready;
    logic [1:0]     cfg_data = '0;
    int             errors, pending, results;
    int             cycles = 0;
    bit             hold_off = 0;
    bit             hold_done = 0;
    bit             gaps_on = 1;

    always begin
        #6 clk = 1;
        #6 clk = 0;
    end

    tanh_piecewise_approximation_top dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(x_valid), .o_stall(x_stall),
        .i_x_value(x_value), .o_valid(y_valid), .i_stall(y_stall),
        .o_y_value(y_value), .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_data(cfg_data));

    tanh_check chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(x_valid), .i_stall_in(x_stall),
        .i_x_value(x_value), .i_out_valid(y_valid), .i_out_stall(y_stall),
        .i_y_value(y_value), .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_data(cfg_data), .o_errors(errors), .o_pending(pending),
        .o_results(results));

    // Timeout guard
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver stall: random per result, or one long hold-off counted here
    initial begin
        int n;
        forever begin
            @(posedge clk);
            if (hold_off && !hold_done) begin
                y_stall <= 1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1;
                y_stall <= 0;
            end else if (gaps_on) begin
                n = $urandom_range(0, 10);
                if (n > 0) begin
                    y_stall <= 1;
                    repeat (n) @(posedge clk);
                end
                y_stall <= 0;
                do @(posedge clk);
                while (!(y_valid && !y_stall) && !(hold_off && !hold_done));
            end else y_stall <= 0;
        end
    end

    // One sample request, with a random gap before it while gaps are on
    task automatic send_sample(logic [X_W-1:0] x);
        int gap;
        gap = gaps_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            x_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        x_valid <= 1;
        x_value <= x;
        do @(posedge clk); while (x_stall);
    endtask

    task automatic drain();
        x_valid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_mode(t_mode m);
        cfg_valid <= 1;
        cfg_data  <= m;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
    endtask

    // Random sample: mostly within the interesting range, sometimes any value
    function automatic logic [X_W-1:0] pick_x();
        logic [X_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = X_W'($urandom);
            1: v = X_W'($urandom_range(0, 12 << IN_FRAC));
            2: v = -X_W'($urandom_range(0, 12 << IN_FRAC));
            default: v = X_W'($signed($urandom_range(0, 2 << IN_FRAC)) - (1 << IN_FRAC));
        endcase
        return v;
    endfunction

    localparam int NDIR = 22;
    logic [X_W-1:0] edge_x [NDIR] = '{
        18'h00000, 18'h00001, 18'h3FFFF, 18'h1FFFF, 18'h20000, 18'h20001,
        18'd2048, 18'd2047, 18'd4864, 18'd4863, 18'd10240, 18'd10239,
        18'd20480, 18'd20481, 18'd1280, 18'd1279, 18'd32768, 18'd32767,
        -18'd2048, -18'd4864, -18'd1, 18'h2AAAA};

    initial begin
        t_mode m;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed corners in every mode, fine table first (reset value)
        for (int k = 0; k < 4; k++) begin
            m = t_mode'(3 - k);
            if (k > 0) write_mode(m);
            for (int i = 0; i < NDIR; i++) send_sample(edge_x[i]);
            drain();
        end

        // Random phases with mode changes
        for (int p = 0; p < 8; p++) begin
            write_mode(t_mode'($urandom_range(0, 3)));
            gaps_on = (p != 3);
            if (p == 5) hold_off = 1;
            for (int i = 0; i < 85; i++) begin
                send_sample(pick_x());
            end
            // sender waits for every outstanding result
            drain();
        end
        gaps_on = 1;
        write_mode(MODE_PLAN);
        for (int i = 0; i < 30; i++) send_sample(pick_x());
        drain();

        $display("Covered corners and %0d results over all four methods,", results);
        $display("with mode writes, random gaps, stalls and a long output hold-off.");
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== tanh_piecewise_approximation_top.f =====
rtl/core/tpa_pkg.sv
rtl/core/tpa_front.sv
rtl/core/tpa_fit_div.sv
rtl/core/tanh_piecewise_approximation_top.sv
rtl/core/tpa_props.sv
tb/tanh_check.sv
tb/tb.sv
